@@ src/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;
    localparam int REQ_W  = 2;

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Register map
    localparam logic CFG_ATTR_ADDR = 1'b0;

    // Row table update issued by the request engine
    typedef struct packed {
        logic              clear;
        logic              scroll;
        logic              put;
        logic [ROW_W-1:0]  put_row;
        logic [COL_W-1:0]  put_fill;
        logic [ATTR_W-1:0] attr;
    } row_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

endpackage

`default_nettype wire

@@ src/tcw_row_map.sv @@
`default_nettype none

// Row table: maps screen rows to physical memory rows through a rotating top
// pointer, and keeps per physical row how many leading cells were written
// since the row was last blanked plus the attribute it was blanked with.
module tcw_row_map
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire row_cmd_t          cmd,
    input  wire logic [ROW_W-1:0]  cur_row,
    input  wire logic [ROW_W-1:0]  look_row,
    output logic      [ROW_W-1:0]  cur_phys,
    output logic      [ROW_W-1:0]  look_phys,
    output logic      [COL_W-1:0]  look_fill,
    output logic      [ATTR_W-1:0] look_attr
);

    logic [ROW_W-1:0]  top_reg;
    logic [COL_W-1:0]  fill_reg [ROWS];
    logic [ATTR_W-1:0] attr_reg [ROWS];
    logic [ROW_W-1:0]  look_row_safe;
    logic [ROW_W-1:0]  top_next;

    function automatic logic [ROW_W-1:0] rotate_row(
        input logic [ROW_W-1:0] row,
        input logic [ROW_W-1:0] top
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // Map logical rows to physical rows
    assign look_row_safe = (look_row < ROW_W'(ROWS)) ? look_row : '0;
    assign cur_phys      = rotate_row(cur_row, top_reg);
    assign look_phys     = rotate_row(look_row_safe, top_reg);
    assign look_fill     = fill_reg[look_phys];
    assign look_attr     = attr_reg[look_phys];

    // Advance the top pointer on scroll
    assign top_next = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;

    // Update row descriptors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i] <= '0;
                attr_reg[i] <= ATTR_RESET;
            end
        end
        else if (cmd.clear)
        begin
            top_reg <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i] <= '0;
                attr_reg[i] <= cmd.attr;
            end
        end
        else
        begin
            if (cmd.put)
            begin
                fill_reg[cmd.put_row] <= cmd.put_fill;
            end
            // old top row becomes the new blank bottom row
            if (cmd.scroll)
            begin
                fill_reg[top_reg] <= '0;
                attr_reg[top_reg] <= cmd.attr;
                top_reg           <= top_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/text_console_char_writer_top.sv @@
`default_nettype none

// An accepted beat passes through EXEC, then FIN, where its result beat is registered
// unless the output stalls. A new request is taken only in IDLE, once the last one has
// left FIN, scroll and clear included (single-port memory access in EXEC, its registered read data in FIN).
// Scroll and clear only update the row table (rotating top row, per-row fill count).
// Reset: cursor at home, attribute 0x0F, every row reads as blank at once; no
// clearing pass, the block takes a request in the first cycle after reset.
module text_console_char_writer_top
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [ROW_W-1:0]  read_row,
    input  wire logic [COL_W-1:0]  read_col,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [CELL_W-1:0] cell_value,
    output logic      [COL_W-1:0]  cursor_col,
    output logic      [ROW_W-1:0]  cursor_row,
    output logic                   scrolled,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    state_t            state_reg, state_next;
    logic [REQ_W-1:0]  req_reg;
    logic [CHAR_W-1:0] code_reg;
    logic [ROW_W-1:0]  rrow_reg;
    logic [COL_W-1:0]  rcol_reg;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ATTR_W-1:0] text_attr_reg;

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              rd_hit_reg;
    logic              rd_blank_reg;
    logic [ATTR_W-1:0] blank_attr_reg;
    logic              scroll_pend_reg;

    logic              out_valid_reg;
    logic [CELL_W-1:0] cell_value_reg, cell_value_next;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROW_W-1:0]  cursor_row_reg;
    logic              scrolled_reg;

    logic              in_fire, exec, out_load, cfg_wr;
    logic              is_put, is_clear, is_read, is_nl;
    logic [COL_W-1:0]  col_inc;
    logic              line_adv, at_last, do_scroll, rd_in_range;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    row_cmd_t          row_cmd;
    logic [ROW_W-1:0]  cur_phys, look_phys;
    logic [COL_W-1:0]  look_fill;
    logic [ATTR_W-1:0] look_attr;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == CFG_ATTR_ADDR);
    assign prdata = (paddr == CFG_ATTR_ADDR) ? {24'b0, text_attr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= ATTR_RESET;
        end
        else if (cfg_wr)
        begin
            text_attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    // Handshake and sequencing
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign exec     = (state_reg == ST_EXEC);
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg  <= req_type;
            code_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
    end

    // Decode the request and work out the cursor move
    assign is_put      = (req_reg == REQ_PUT);
    assign is_clear    = (req_reg == REQ_CLEAR);
    assign is_read     = (req_reg == REQ_READ);
    assign is_nl       = (code_reg == NL_CODE);
    assign col_inc     = cur_col_reg + 1'b1;
    assign line_adv    = is_put && (is_nl || (col_inc == COL_W'(COLUMNS)));
    assign at_last     = (cur_row_reg == LAST_ROW);
    assign do_scroll   = line_adv && at_last;
    assign rd_in_range = (rrow_reg < ROW_W'(ROWS)) && (rcol_reg < COL_W'(COLUMNS));

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        priority if (is_clear)
        begin
            cur_col_next = '0;
            cur_row_next = '0;
        end
        else if (line_adv)
        begin
            cur_col_next = '0;
            if (!at_last)
            begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
        else if (is_put)
        begin
            cur_col_next = col_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else if (exec)
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    // Row table
    always_comb
    begin
        row_cmd          = '0;
        row_cmd.clear    = exec && is_clear;
        row_cmd.scroll   = exec && do_scroll;
        row_cmd.put      = exec && is_put && !is_nl;
        row_cmd.put_row  = cur_phys;
        row_cmd.put_fill = col_inc;
        row_cmd.attr     = text_attr_reg;
    end

    tcw_row_map u_row_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (row_cmd),
        .cur_row   (cur_row_reg),
        .look_row  (rrow_reg),
        .cur_phys  (cur_phys),
        .look_phys (look_phys),
        .look_fill (look_fill),
        .look_attr (look_attr)
    );

    // Screen memory; one request at a time, so a write and a later read never overlap
    assign mem_we    = exec && is_put && !is_nl;
    assign mem_waddr = cell_addr(cur_phys, cur_col_reg);
    assign mem_wdata = {text_attr_reg, code_reg};
    assign mem_re    = exec && is_read && rd_in_range;
    assign mem_raddr = cell_addr(look_phys, rcol_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    // Hold read selection for the finish cycle
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rd_hit_reg      <= is_read && rd_in_range;
            rd_blank_reg    <= (rcol_reg >= look_fill);
            blank_attr_reg  <= look_attr;
            scroll_pend_reg <= do_scroll;
        end
    end

    // Result register
    always_comb
    begin
        cell_value_next = '0;
        if (rd_hit_reg)
        begin
            cell_value_next = rd_blank_reg ? {blank_attr_reg, SPACE_CODE} : rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cell_value_reg <= cell_value_next;
            cursor_col_reg <= cur_col_reg;
            cursor_row_reg <= cur_row_reg;
            scrolled_reg   <= scroll_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign scrolled   = scrolled_reg;

    // Checks
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_EXEC))
        else $error("screen write outside execute cycle");

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg < ROW_W'(ROWS)) && (cur_col_reg < COL_W'(COLUMNS)))
        else $error("cursor off screen");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("finish did not present a result");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && scrolled_reg) |-> ((cursor_row_reg == LAST_ROW) && (cursor_col_reg == '0)))
        else $error("scroll left cursor away from start of last row");

    a_read_only_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !rd_hit_reg) |=> (cell_value_reg == '0))
        else $error("nonzero cell value on a non-read request");

endmodule

`default_nettype wire
